// ===== rtl/bdr_pkg.sv =====
// shared types and constants for the button debounce / repeat / long press block
`timescale 1ns / 1ps

package bdr_pkg;

    localparam int BDR_NUM_BUTTONS = 8;
    localparam int FIELD_W         = 8;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REP_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REP_WAIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE = 3'd5;

    // reset values
    localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd20;
    localparam logic [CFG_W-1:0] RST_REP_INTERVAL = 16'd100;
    localparam logic [CFG_W-1:0] RST_REP_WAIT     = 16'd200;
    localparam logic [CFG_W-1:0] RST_LONG_WAIT    = 16'd3000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] repeat_interval_ms;
        logic [CFG_W-1:0] repeat_wait_ms;
        logic [CFG_W-1:0] long_wait_ms;
        logic             repeat_enable;
        logic             long_enable;
    } t_cfg;

    typedef struct packed {
        logic [FIELD_W-1:0] buttons;
        logic [TIME_W-1:0]  now_ms;
    } t_sample;

endpackage

// ===== rtl/bdr_ifs.sv =====
// valid/ready channel interfaces for sample words and result words
`timescale 1ns / 1ps

interface bdr_in_if;
    logic                    valid;
    logic                    ready;
    logic [bdr_pkg::FIELD_W-1:0] buttons;
    logic [bdr_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output buttons, output now_ms, input ready);
    modport sink   (input valid, input buttons, input now_ms, output ready);
endinterface

interface bdr_out_if;
    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic [bdr_pkg::FIELD_W-1:0] stable_state;
    logic [bdr_pkg::FIELD_W-1:0] down_mask;
    logic [bdr_pkg::FIELD_W-1:0] up_mask;
    logic [bdr_pkg::FIELD_W-1:0] press_mask;
    logic [bdr_pkg::FIELD_W-1:0] long_mask;

    modport source (output valid, output accepted, output stable_state, output down_mask,
                    output up_mask, output press_mask, output long_mask, input ready);
    modport sink   (input valid, input accepted, input stable_state, input down_mask,
                    input up_mask, input press_mask, input long_mask, output ready);
endinterface

// ===== rtl/bdr_cfg.sv =====
// configuration register file
`timescale 1ns / 1ps

module bdr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdr_pkg::CFG_W-1:0]      i_cfg_data,
    output bdr_pkg::t_cfg                  o_cfg
);
    import bdr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= RST_DEBOUNCE;
            r_cfg.repeat_interval_ms <= RST_REP_INTERVAL;
            r_cfg.repeat_wait_ms     <= RST_REP_WAIT;
            r_cfg.long_wait_ms       <= RST_LONG_WAIT;
            r_cfg.repeat_enable      <= 1'b0;
            r_cfg.long_enable        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEBOUNCE:     r_cfg.debounce_ms        <= i_cfg_data;
                REG_REP_INTERVAL: r_cfg.repeat_interval_ms <= i_cfg_data;
                REG_REP_WAIT:     r_cfg.repeat_wait_ms     <= i_cfg_data;
                REG_LONG_WAIT:    r_cfg.long_wait_ms       <= i_cfg_data;
                REG_REP_ENABLE:   r_cfg.repeat_enable      <= i_cfg_data[0];
                REG_LONG_ENABLE:  r_cfg.long_enable        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bdr_in_stage.sv =====
// input register stage for sample words
`timescale 1ns / 1ps

module bdr_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bdr_in_if.sink           i_in,
    input  logic             i_adv,
    output logic             o_valid,
    output bdr_pkg::t_sample o_sample
);
    import bdr_pkg::*;

    logic    r_valid;
    t_sample r_sample;
    logic    w_take;

    // refill in the same cycle the held word moves on
    assign i_in.ready = !r_valid || i_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sample.buttons <= i_in.buttons;
            r_sample.now_ms  <= i_in.now_ms;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

// ===== rtl/bdr_core.sv =====
// debounce, autorepeat and long press state with the result register
`timescale 1ns / 1ps

module bdr_core #(
    parameter int NUM_BUTTONS = bdr_pkg::BDR_NUM_BUTTONS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdr_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  bdr_pkg::t_sample i_sample,
    output logic             o_adv,
    bdr_out_if.source        o_out
);
    import bdr_pkg::*;

    localparam int ACT = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;

    logic [ACT-1:0]    r_prev;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_last_down;
    logic [TIME_W-1:0] r_last_repeat;
    logic              r_long_done;

    logic [ACT-1:0]    n_prev;
    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_last_down;
    logic [TIME_W-1:0] n_last_repeat;
    logic              n_long_done;

    logic              r_out_valid;
    logic              r_acc;
    logic [ACT-1:0]    r_stable, r_down, r_up, r_press, r_long;
    logic              n_acc;
    logic [ACT-1:0]    n_down, n_up, n_press, n_long;

    logic [ACT-1:0]    w_cur;
    logic [TIME_W-1:0] w_now;
    logic [TIME_W-1:0] w_el_change, w_el_down, w_el_repeat;
    logic              w_deb_ok, w_rwait_ok, w_rint_ok, w_long_ok;

    assign w_cur = i_sample.buttons[ACT-1:0];
    assign w_now = i_sample.now_ms;

    // wrapping elapsed times, limits compared strictly greater
    assign w_el_change = w_now - r_last_change;
    assign w_el_down   = w_now - r_last_down;
    assign w_el_repeat = w_now - r_last_repeat;
    assign w_deb_ok    = w_el_change > TIME_W'(i_cfg.debounce_ms);
    assign w_rwait_ok  = w_el_down   > TIME_W'(i_cfg.repeat_wait_ms);
    assign w_rint_ok   = w_el_repeat > TIME_W'(i_cfg.repeat_interval_ms);
    assign w_long_ok   = w_el_down   > TIME_W'(i_cfg.long_wait_ms);

    assign o_adv = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_prev        = r_prev;
        n_last_change = r_last_change;
        n_last_down   = r_last_down;
        n_last_repeat = r_last_repeat;
        n_long_done   = r_long_done;
        n_acc         = 1'b0;
        n_down        = '0;
        n_up          = '0;
        n_press       = '0;
        n_long        = '0;

        // an all-released sample rearms the long press
        if (w_cur == '0) begin
            n_long_done = 1'b0;
        end

        if (w_cur != r_prev) begin
            if (w_deb_ok) begin
                if (r_prev == '0) begin
                    n_last_down   = w_now;
                    n_last_repeat = w_now;
                end
                n_down = w_cur & ~r_prev;
                n_up   = r_prev & ~w_cur;
                if (i_cfg.repeat_enable) begin
                    n_press = w_cur & ~r_prev;
                end
                n_prev        = w_cur;
                n_last_change = w_now;
                n_acc         = 1'b1;
            end
        end else if (i_cfg.repeat_enable && w_cur != '0) begin
            if (w_rwait_ok && w_rint_ok) begin
                n_press       = w_cur;
                n_last_repeat = w_now;
            end
        end else if (i_cfg.long_enable && w_cur != '0 && !r_long_done) begin
            if (w_long_ok) begin
                n_long_done = 1'b1;
                n_long      = w_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_last_change <= '0;
            r_last_down   <= '0;
            r_last_repeat <= '0;
            r_long_done   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_adv) begin
                r_prev        <= n_prev;
                r_last_change <= n_last_change;
                r_last_down   <= n_last_down;
                r_last_repeat <= n_last_repeat;
                r_long_done   <= n_long_done;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_acc    <= n_acc;
            r_stable <= n_prev;
            r_down   <= n_down;
            r_up     <= n_up;
            r_press  <= n_press;
            r_long   <= n_long;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.accepted     = r_acc;
    assign o_out.stable_state = FIELD_W'(r_stable);
    assign o_out.down_mask    = FIELD_W'(r_down);
    assign o_out.up_mask      = FIELD_W'(r_up);
    assign o_out.press_mask   = FIELD_W'(r_press);
    assign o_out.long_mask    = FIELD_W'(r_long);

endmodule

// ===== rtl/button_debounce_repeat_long.sv =====
// top level: button debouncer with autorepeat and one-shot long press
// path: a sample word accepted passes the input register, then the result register,
//   before its result word is valid
// throughput: one sample word per cycle while no result word is stalled; the state update
//   is one pass of three 32-bit subtracts, four compares and bit logic in the result stage
// reset: synchronous active-low; clears config to defaults, all timers,
//   the accepted state, the long press flag and both valid flags
`timescale 1ns / 1ps

module button_debounce_repeat_long #(
    parameter int NUM_BUTTONS = bdr_pkg::BDR_NUM_BUTTONS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bdr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bdr_pkg::CFG_W-1:0]     i_cfg_data,
    bdr_in_if.sink                        i_in,
    bdr_out_if.source                     o_out
);
    import bdr_pkg::*;

    t_cfg    w_cfg;
    t_sample w_sample;
    logic    w_valid;
    logic    w_adv;

    bdr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bdr_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_adv    (w_adv),
        .o_valid  (w_valid),
        .o_sample (w_sample)
    );

    bdr_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_valid),
        .i_sample (w_sample),
        .o_adv    (w_adv),
        .o_out    (o_out)
    );

    // input side only backs up when a result word is stuck
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a stalled result");

    // down and up masks only on an accepted change, and never overlap
    a_masks_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.accepted) |-> (o_out.down_mask == '0 && o_out.up_mask == '0))
        else $error("change masks without accepted change");

    a_acc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |->
            ((o_out.down_mask | o_out.up_mask) != '0 && (o_out.down_mask & o_out.up_mask) == '0))
        else $error("accepted change with bad masks");

    // long press is exclusive of change and repeat reports
    a_long_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.long_mask != '0) |->
            (!o_out.accepted && o_out.press_mask == '0 && o_out.long_mask == o_out.stable_state))
        else $error("long press overlaps another report");

endmodule

// ===== verif/button_debounce_repeat_long_tb.sv =====
// testbench for the button debouncer: directed sample table, then random timed press sequences
`timescale 1ns / 1ps

module button_debounce_repeat_long_tb;
    import bdr_pkg::*;

    localparam int LATENCY          = 2;
    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 102;
    localparam int PRESSURE_CYCLES  = 64;
    localparam int LIMIT_NS         = 5_000_000;
    localparam logic [FIELD_W-1:0] BTN_MASK = FIELD_W'((1 << BDR_NUM_BUTTONS) - 1);

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum {CFG_ALL_ZERO, CFG_ALL_MAX, CFG_RANDOM} t_cfg_mode;
    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        logic               accepted;
        logic [FIELD_W-1:0] stable_state;
        logic [FIELD_W-1:0] down_mask;
        logic [FIELD_W-1:0] up_mask;
        logic [FIELD_W-1:0] press_mask;
        logic [FIELD_W-1:0] long_mask;
    } t_result;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [FIELD_W-1:0]   buttons;
        logic [TIME_W-1:0]    now_ms;
        bit                   typed;
        t_result              res;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bdr_in_if  smp_if ();
    bdr_out_if res_if ();

    button_debounce_repeat_long dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (smp_if),
        .o_out      (res_if)
    );

    // shadow of the block: config and debounce state
    t_cfg               cfg_sh;
    logic [FIELD_W-1:0] st_stable;
    logic [TIME_W-1:0]  st_change_ms;
    logic [TIME_W-1:0]  st_down_ms;
    logic [TIME_W-1:0]  st_repeat_ms;
    logic               st_long_done;

    t_result   expected_q[$];
    t_stim_row stim_rows[$];
    int        mismatch_cnt = 0;
    bit        quiet = 1'b0;
    bit        pressure_req = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #(LIMIT_NS);
        $display("[button_debounce_repeat_long] ERROR");
        $finish;
    end

    function automatic bit past(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stamp,
                                input logic [CFG_W-1:0] limit);
        logic [TIME_W-1:0] d;
        d = now - stamp;
        return d > {{(TIME_W - CFG_W){1'b0}}, limit};
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] d);
        case (idx)
            REG_DEBOUNCE:     cfg_sh.debounce_ms        = d;
            REG_REP_INTERVAL: cfg_sh.repeat_interval_ms = d;
            REG_REP_WAIT:     cfg_sh.repeat_wait_ms     = d;
            REG_LONG_WAIT:    cfg_sh.long_wait_ms       = d;
            REG_REP_ENABLE:   cfg_sh.repeat_enable      = d[0];
            REG_LONG_ENABLE:  cfg_sh.long_enable        = d[0];
            default: ;
        endcase
    endfunction

    function automatic t_result debounce_step(input logic [FIELD_W-1:0] b,
                                              input logic [TIME_W-1:0] now);
        t_result            r;
        logic [FIELD_W-1:0] cur;
        r = '0;
        cur = b & BTN_MASK;
        if (cur == '0)
            st_long_done = 1'b0;
        if (cur != st_stable) begin
            if (past(now, st_change_ms, cfg_sh.debounce_ms)) begin
                // leaving all-released restarts the hold timers
                if (st_stable == '0) begin
                    st_down_ms   = now;
                    st_repeat_ms = now;
                end
                r.down_mask = cur & ~st_stable;
                r.up_mask   = st_stable & ~cur;
                if (cfg_sh.repeat_enable)
                    r.press_mask = r.down_mask;
                st_stable    = cur;
                st_change_ms = now;
                r.accepted   = 1'b1;
            end
        end else if (cfg_sh.repeat_enable && cur != '0) begin
            if (past(now, st_down_ms, cfg_sh.repeat_wait_ms) &&
                past(now, st_repeat_ms, cfg_sh.repeat_interval_ms)) begin
                r.press_mask = cur;
                st_repeat_ms = now;
            end
        end else if (cfg_sh.long_enable && cur != '0 && !st_long_done) begin
            if (past(now, st_down_ms, cfg_sh.long_wait_ms)) begin
                st_long_done = 1'b1;
                r.long_mask  = cur;
            end
        end
        r.stable_state = st_stable;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] pick_ms(input t_cfg_mode mode, input int cap);
        if (mode == CFG_ALL_ZERO)
            return '0;
        if (mode == CFG_ALL_MAX)
            return '1;
        if ($urandom_range(0, 9) == 0)
            return CFG_W'($urandom);
        return CFG_W'($urandom_range(0, cap));
    endfunction

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] exp_v,
                                        input logic [FIELD_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatch_cnt++;
        end
    endfunction

    function automatic void add_sample(input logic [FIELD_W-1:0] b, input logic [TIME_W-1:0] t);
        t_stim_row row;
        row = '{ROW_SAMPLE, '0, '0, b, t, 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [FIELD_W-1:0] b, input logic [TIME_W-1:0] t,
                                        input logic acc, input logic [FIELD_W-1:0] st,
                                        input logic [FIELD_W-1:0] dn, input logic [FIELD_W-1:0] up,
                                        input logic [FIELD_W-1:0] pr,
                                        input logic [FIELD_W-1:0] lg);
        t_stim_row row;
        row = '{ROW_SAMPLE, '0, '0, b, t, 1'b1, '{acc, st, dn, up, pr, lg}};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        t_stim_row row;
        row = '{ROW_WRITE, idx, d, '0, '0, 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_reg(idx, d);
    endtask

    task automatic send_sample(input logic [FIELD_W-1:0] b, input logic [TIME_W-1:0] t,
                               input bit typed, input t_result typed_r);
        int      gap;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.buttons <= b;
        smp_if.now_ms  <= t;
        do @(posedge i_clk); while (smp_if.ready !== 1'b1);
        r = debounce_step(b, t);
        expected_q.push_back(typed ? typed_r : r);
    endtask

    // drop valid, let every result word drain, then allow the pipe to settle
    task automatic wait_idle();
        smp_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // result side: checks words and stalls at random
    initial begin : result_sink
        int      stall_left;
        logic    nxt_ready;
        t_result exp_r;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatch_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("accepted", FIELD_W'(exp_r.accepted), FIELD_W'(res_if.accepted));
                    check_field("stable_state", exp_r.stable_state, res_if.stable_state);
                    check_field("down_mask", exp_r.down_mask, res_if.down_mask);
                    check_field("up_mask", exp_r.up_mask, res_if.up_mask);
                    check_field("press_mask", exp_r.press_mask, res_if.press_mask);
                    check_field("long_mask", exp_r.long_mask, res_if.long_mask);
                end
            end
            if (pressure_req) begin
                pressure_req = 1'b0;
                stall_left = PRESSURE_CYCLES;
            end else if (stall_left == 0 && i_rst_n) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                nxt_ready = 1'b0;
                stall_left--;
            end else begin
                nxt_ready = 1'b1;
            end
            res_if.ready <= nxt_ready;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0]   deb, ivl, rw, lw;
        logic [FIELD_W-1:0] held_pat, btn;
        logic [TIME_W-1:0]  clk_ms;
        t_cfg_mode          mode;
        int                 span, r;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_data     <= '0;
        smp_if.valid   <= 1'b0;
        smp_if.buttons <= '0;
        smp_if.now_ms  <= '0;

        cfg_sh = '{RST_DEBOUNCE, RST_REP_INTERVAL, RST_REP_WAIT, RST_LONG_WAIT, 1'b0, 1'b0};
        st_stable    = '0;
        st_change_ms = '0;
        st_down_ms   = '0;
        st_repeat_ms = '0;
        st_long_done = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: debounce boundary and time wrap
        add_checked(8'h00, 32'h0000_0005, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_checked(8'hFF, 32'h0000_0014, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_checked(8'hFF, 32'h0000_0015, 1'b1, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        add_checked(8'h00, 32'h0000_0029, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        add_checked(8'h00, 32'hFFFF_FFFF, 1'b1, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
        add_checked(8'h01, 32'h0000_0014, 1'b1, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00);
        add_sample(8'h81, 32'h0000_0030);
        // autorepeat with zero waits
        add_write(REG_REP_ENABLE, 16'h0001);
        add_write(REG_REP_WAIT, 16'h0000);
        add_write(REG_REP_INTERVAL, 16'h0000);
        add_write(REG_DEBOUNCE, 16'h0000);
        add_sample(8'h81, 32'h0000_0031);
        add_sample(8'h81, 32'h0000_0031);
        add_sample(8'h7E, 32'h0000_0032);
        // long press at the longest wait, one shot per hold
        add_write(REG_REP_ENABLE, 16'hFFFE);
        add_write(REG_LONG_ENABLE, 16'h0001);
        add_write(REG_LONG_WAIT, 16'hFFFF);
        add_sample(8'h7E, 32'h0001_0032);
        add_sample(8'h7E, 32'h0002_0000);
        add_sample(8'h00, 32'h0002_0001);
        add_sample(8'h00, 32'h0002_0002);
        // rejected release still rearms the long press
        add_write(REG_DEBOUNCE, 16'hFFFF);
        add_write(REG_LONG_WAIT, 16'h0000);
        add_write(REG_SPARE_6, 16'h0000);
        add_write(REG_SPARE_7, 16'hFFFF);
        add_sample(8'h5A, 32'h0003_0000);
        add_sample(8'h5A, 32'h0003_0001);
        add_sample(8'h5A, 32'h0003_0002);
        add_sample(8'h00, 32'h0003_0003);
        add_sample(8'h5A, 32'h0003_0004);
        add_write(REG_DEBOUNCE, RST_DEBOUNCE);
        add_write(REG_LONG_ENABLE, 16'hFFFE);
        add_sample(8'hA5, 32'hFFFF_FFF0);
        add_sample(8'hFF, 32'hFFFF_FFFF);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_sample(stim_rows[i].buttons, stim_rows[i].now_ms,
                            stim_rows[i].typed, stim_rows[i].res);
            end
        end

        held_pat = '0;
        clk_ms = $urandom;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            quiet = (ph == 3 || ph == 5 || ph == 8);
            mode = (ph == 0) ? CFG_ALL_ZERO : (ph == 1) ? CFG_ALL_MAX : CFG_RANDOM;
            if (ph == 2)
                clk_ms = 32'hFFFF_F000;
            deb = pick_ms(mode, 40);
            ivl = pick_ms(mode, 60);
            rw  = pick_ms(mode, 150);
            lw  = pick_ms(mode, 400);
            write_reg(REG_DEBOUNCE, deb);
            write_reg(REG_REP_INTERVAL, ivl);
            write_reg(REG_REP_WAIT, rw);
            write_reg(REG_LONG_WAIT, lw);
            write_reg(REG_REP_ENABLE, CFG_W'($urandom));
            write_reg(REG_LONG_ENABLE, CFG_W'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_W'($urandom));
            // time steps scale with the longest configured wait
            span = deb;
            if (ivl > span) span = ivl;
            if (rw > span) span = rw;
            if (lw > span) span = lw;
            span = span / 6 + 8;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 5 && n == 20)
                    pressure_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 8)
                    clk_ms = $urandom;
                else if (r < 13)
                    clk_ms = clk_ms + $urandom_range(0, 70000);
                else
                    clk_ms = clk_ms + $urandom_range(0, span);
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    btn = held_pat;
                end else if (r < 72) begin
                    held_pat = FIELD_W'($urandom_range(1, 255));
                    btn = held_pat;
                end else if (r < 77) begin
                    held_pat = '0;
                    btn = '0;
                end else if (r < 90) begin
                    // contact bounce on one bit
                    btn = held_pat ^ (8'h01 << $urandom_range(0, FIELD_W - 1));
                end else begin
                    btn = FIELD_W'($urandom);
                end
                send_sample(btn, clk_ms, 1'b0, '0);
            end
        end

        wait_idle();
        if (mismatch_cnt == 0)
            $display("[button_debounce_repeat_long] OK");
        else
            $display("[button_debounce_repeat_long] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bdr_pkg.sv
rtl/bdr_ifs.sv
rtl/bdr_cfg.sv
rtl/bdr_in_stage.sv
rtl/bdr_core.sv
rtl/button_debounce_repeat_long.sv
verif/button_debounce_repeat_long_tb.sv
